@@ rtl/core/radial_wipe_alpha_unit_defines.svh @@
// Assertion macros for the radial wipe alpha unit.
// Used by radial_wipe_alpha_unit.sv; no other dependencies.
`ifndef RADIAL_WIPE_ALPHA_UNIT_DEFINES_SVH
`define RADIAL_WIPE_ALPHA_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define RWA_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");
`define RWA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define RWA_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define RWA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

@@ rtl/core/rwa_pkg.sv @@
// Shared types, constants and the arctangent table of the radial wipe alpha unit.
// No dependencies.
package rwa_pkg;

    localparam int ANGLE_BITS_DEF   = 16;
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int TABLE_LEN        = 24;
    localparam int CNT_W            = 5;

    localparam logic [15:0] DEFAULT_TOTAL = 16'd60;
    // 0.05 of a turn as a 32-bit turn fraction.
    localparam logic [27:0] BAND32 = 28'd214748365;

    typedef struct packed {
        logic               op;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
    } t_in_beat;

    typedef struct packed {
        logic [7:0] vertex_alpha;
        logic [7:0] overall_opacity;
    } t_out_beat;

    // atan(2^-i) as a 32-bit turn fraction, rounded.
    function automatic logic [31:0] atan_turn(input logic [CNT_W-1:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:    v = 32'd536870912;
            5'd1:    v = 32'd316933406;
            5'd2:    v = 32'd167458907;
            5'd3:    v = 32'd85004756;
            5'd4:    v = 32'd42667331;
            5'd5:    v = 32'd21354465;
            5'd6:    v = 32'd10679838;
            5'd7:    v = 32'd5340245;
            5'd8:    v = 32'd2670163;
            5'd9:    v = 32'd1335087;
            5'd10:   v = 32'd667544;
            5'd11:   v = 32'd333772;
            5'd12:   v = 32'd166886;
            5'd13:   v = 32'd83443;
            5'd14:   v = 32'd41722;
            5'd15:   v = 32'd20861;
            5'd16:   v = 32'd10430;
            5'd17:   v = 32'd5215;
            5'd18:   v = 32'd2608;
            5'd19:   v = 32'd1304;
            5'd20:   v = 32'd652;
            5'd21:   v = 32'd326;
            5'd22:   v = 32'd163;
            5'd23:   v = 32'd81;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

@@ rtl/core/radial_wipe_alpha_unit.sv @@
// Radial clock-wipe alpha generator: frame ticks and vertex alpha queries.
// Depends on rwa_pkg and radial_wipe_alpha_unit_defines.svh.
//
// Usage: input beats (op, pos_x, pos_y) arrive on a valid/ready channel and
// each produces exactly one output beat (vertex_alpha, overall_opacity).
// A tick (op 0) advances the elapsed-frame count, saturating at total_frames,
// and recomputes progress with a restoring divider, one quotient bit a cycle.
// A query (op 1) runs an iterative CORDIC, one rotation per cycle, then maps
// the angle against the current progress; inside the soft band the same
// divider produces the alpha. One item is in work at a time; the next beat
// can be accepted in the cycle after a result loads. The output register
// holds a finished beat while the receiver stalls; the next input beat is
// accepted and worked on meanwhile, and its result waits until the register
// frees. Reset clears the count and progress to zero and sets total_frames
// to 60; a total of zero is treated as 60. Writes to total_frames take
// effect at the next tick.
`include "radial_wipe_alpha_unit_defines.svh"

module radial_wipe_alpha_unit #(
    parameter int ANGLE_BITS   = rwa_pkg::ANGLE_BITS_DEF,
    parameter int CORDIC_STEPS = rwa_pkg::CORDIC_STEPS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  rwa_pkg::t_in_beat i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output rwa_pkg::t_out_beat o_out_data,
    input  logic              i_cfg_we,
    input  logic [15:0]       i_cfg_wdata
);

    localparam int SH = 32 - ANGLE_BITS;
    localparam logic [31:0] HALF = 32'd1 << (SH - 1);
    localparam int OFF_INT = ((1 << ANGLE_BITS) + 12) / 24;
    localparam logic [ANGLE_BITS-1:0] OFF = ANGLE_BITS'(OFF_INT);
    localparam logic [rwa_pkg::CNT_W-1:0] LAST_ROT = rwa_pkg::CNT_W'(CORDIC_STEPS - 1);
    localparam logic [rwa_pkg::CNT_W-1:0] LAST_PROG = rwa_pkg::CNT_W'(16);
    localparam logic [rwa_pkg::CNT_W-1:0] LAST_ALPHA = rwa_pkg::CNT_W'(7);

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_TICK   = 8'b0000_0010,
        S_CORDIC = 8'b0000_0100,
        S_ANGLE  = 8'b0000_1000,
        S_BAND   = 8'b0001_0000,
        S_SCALE  = 8'b0010_0000,
        S_DIV    = 8'b0100_0000,
        S_DONE   = 8'b1000_0000
    } t_state;

    t_state                      r_state;
    logic [15:0]                 r_total;
    logic [15:0]                 r_elapsed;
    logic [16:0]                 r_progress;
    logic                        r_op;
    logic                        r_zero;
    logic signed [35:0]          r_x;
    logic signed [35:0]          r_y;
    logic [31:0]                 r_acc;
    logic [rwa_pkg::CNT_W-1:0]   r_cnt;
    logic [rwa_pkg::CNT_W-1:0]   r_div_last;
    logic [36:0]                 r_rem;
    logic [36:0]                 r_dv;
    logic [16:0]                 r_quot;
    logic [7:0]                  r_alpha;
    logic                        r_out_valid;
    rwa_pkg::t_out_beat          r_out_data;

    logic [36:0]                 n_rem;
    logic [16:0]                 n_quot;

    logic                        in_acc;
    logic signed [31:0]          x32;
    logic signed [31:0]          y32;
    logic signed [35:0]          x36;
    logic signed [35:0]          y36;
    logic signed [35:0]          xs;
    logic signed [35:0]          ys;
    logic [31:0]                 rnd_sum;
    logic [ANGLE_BITS-1:0]       ang;
    logic [ANGLE_BITS-1:0]       ang_off;
    logic signed [35:0]          p32_s;
    logic signed [35:0]          lo_s;
    logic signed [35:0]          a32_s;
    logic signed [35:0]          dist_s;
    logic [15:0]                 total_eff;
    logic [16:0]                 elapsed_inc;
    logic [15:0]                 elapsed_sat;
    logic [16:0]                 remain;
    logic [24:0]                 opac_prod;
    logic                        out_free;

    assign in_acc      = i_in_valid && o_in_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
    assign out_free    = !r_out_valid || i_out_ready;

    always_comb begin
        x32 = {i_in_data.pos_x, 16'h0000};
        y32 = {i_in_data.pos_y, 16'h0000};
        x36 = 36'(x32);
        y36 = 36'(y32);
        xs  = r_x >>> r_cnt;
        ys  = r_y >>> r_cnt;

        rnd_sum = r_acc + HALF;
        ang     = r_zero ? '0 : rnd_sum[31:SH];
        ang_off = ang - OFF;

        p32_s  = 36'({r_progress, 16'h0000});
        lo_s   = p32_s - 36'(rwa_pkg::BAND32);
        a32_s  = 36'(r_acc);
        dist_s = a32_s - lo_s;

        total_eff   = (r_total == 16'd0) ? rwa_pkg::DEFAULT_TOTAL : r_total;
        elapsed_inc = {1'b0, r_elapsed} + 17'd1;
        elapsed_sat = (elapsed_inc > {1'b0, total_eff}) ? total_eff : elapsed_inc[15:0];

        // Restoring division: one compare and subtract per quotient bit.
        if (r_rem >= r_dv) begin
            n_rem  = r_rem - r_dv;
            n_quot = {r_quot[15:0], 1'b1};
        end else begin
            n_rem  = r_rem;
            n_quot = {r_quot[15:0], 1'b0};
        end

        // Opacity is 255 * (1 - progress), with 255*q formed as q*256 - q.
        remain    = 17'h10000 - r_progress;
        opac_prod = {remain, 8'h00} - 25'(remain);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= rwa_pkg::DEFAULT_TOTAL;
        end else if (i_cfg_we) begin
            r_total <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_elapsed   <= '0;
            r_progress  <= '0;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
        end else begin
            // In S_DONE the output register is reloaded below instead.
            if (r_out_valid && i_out_ready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_op   <= i_in_data.op;
                        r_cnt  <= '0;
                        r_zero <= (i_in_data.pos_x == 16'sd0) && (i_in_data.pos_y == 16'sd0);
                        // Fold the left half-plane onto the right one.
                        if (x36 < 0) begin
                            r_x   <= -x36;
                            r_y   <= -y36;
                            r_acc <= 32'h8000_0000;
                        end else begin
                            r_x   <= x36;
                            r_y   <= y36;
                            r_acc <= 32'h0000_0000;
                        end
                        r_state <= i_in_data.op ? S_CORDIC : S_TICK;
                    end
                end
                S_TICK: begin
                    r_elapsed  <= elapsed_sat;
                    r_rem      <= 37'({elapsed_sat, 16'h0000});
                    r_dv       <= 37'({total_eff, 16'h0000});
                    r_quot     <= '0;
                    r_cnt      <= '0;
                    r_div_last <= LAST_PROG;
                    r_state    <= S_DIV;
                end
                S_CORDIC: begin
                    if (!r_y[35]) begin
                        r_x   <= r_x + ys;
                        r_y   <= r_y - xs;
                        r_acc <= r_acc + rwa_pkg::atan_turn(r_cnt);
                    end else begin
                        r_x   <= r_x - ys;
                        r_y   <= r_y + xs;
                        r_acc <= r_acc - rwa_pkg::atan_turn(r_cnt);
                    end
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == LAST_ROT) begin
                        r_state <= S_ANGLE;
                    end
                end
                S_ANGLE: begin
                    // Round to the angle width, rotate by 1/24 turn, widen again.
                    r_acc   <= {ang_off, SH'(0)};
                    r_state <= S_BAND;
                end
                S_BAND: begin
                    if (a32_s <= lo_s) begin
                        r_alpha <= 8'd0;
                        r_state <= S_DONE;
                    end else if (a32_s <= p32_s) begin
                        r_rem   <= 37'(dist_s);
                        r_state <= S_SCALE;
                    end else begin
                        r_alpha <= 8'd255;
                        r_state <= S_DONE;
                    end
                end
                S_SCALE: begin
                    r_rem      <= {r_rem[28:0], 8'h00} - r_rem;
                    r_dv       <= 37'({rwa_pkg::BAND32, 7'h00});
                    r_quot     <= '0;
                    r_cnt      <= '0;
                    r_div_last <= LAST_ALPHA;
                    r_state    <= S_DIV;
                end
                S_DIV: begin
                    r_rem  <= n_rem;
                    r_quot <= n_quot;
                    r_dv   <= r_dv >> 1;
                    r_cnt  <= r_cnt + 1'b1;
                    if (r_cnt == r_div_last) begin
                        if (r_op) begin
                            r_alpha <= n_quot[7:0];
                        end else begin
                            r_progress <= n_quot;
                            r_alpha    <= 8'd0;
                        end
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out_valid                <= 1'b1;
                        r_out_data.vertex_alpha    <= r_alpha;
                        r_out_data.overall_opacity <= opac_prod[23:16];
                        r_state                    <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // An accepted beat leaves the sequencer busy in the following cycle.
    `RWA_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, in_acc, !o_in_ready)
    // Restoring division invariant: the partial remainder stays below twice the divisor.
    `RWA_ASSERT_IMPL(a_div_bound, i_clk, i_rst_n, r_state == S_DIV, r_rem < (r_dv << 1))
    // A tick never reports a vertex alpha.
    `RWA_ASSERT_IMPL(a_tick_alpha_zero, i_clk, i_rst_n, (r_state == S_DONE) && !r_op, r_alpha == 8'd0)
    // A finished beat is not dropped while the receiver stalls.
    `RWA_ASSERT_NEXT(a_out_held, i_clk, i_rst_n, r_out_valid && !i_out_ready, r_out_valid)

endmodule
